/* rtl/trd_pkg.sv */
// Package for the TGA RLE pixel decoder: payload structs, job record between
// front and back end, register index and depth codes. No dependencies.
`timescale 1ns / 1ps

package trd_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [7:0] pal_index;
    logic [7:0] pal_blue;
    logic [7:0] pal_green;
    logic [7:0] pal_red;
  } item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic [7:0] repeat_count;
    logic       frame_end;
  } result_t;

  typedef enum logic [1:0] {
    OP_PAL_WRITE,
    OP_PIXEL,
    OP_PAL_PIXEL
  } job_op_t;

  typedef struct packed {
    job_op_t    op;
    logic [7:0] index;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] rep;
    logic       frame_end;
  } job_t;

  localparam logic [1:0] CFG_DEPTH_MODE     = 2'd0;
  localparam logic [1:0] CFG_RLE_ENABLE     = 2'd1;
  localparam logic [1:0] CFG_PALETTE_ENABLE = 2'd2;
  localparam logic [1:0] CFG_PIXEL_TOTAL    = 2'd3;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  localparam logic       FUNC_PAL_WRITE = 1'b0;
  localparam int         FRAME_W        = 30;
  localparam logic [7:0] RUN_MASK       = 8'h7f;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

endpackage

/* rtl/trd_front.sv */
// Front end: configuration registers, RLE packet state, byte assembly and
// frame counting. Emits one job per palette write or finished pixel. Uses trd_pkg.
`timescale 1ns / 1ps

module trd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [trd_pkg::FRAME_W-1:0] cfg_data,
  input  logic                        accept,
  input  trd_pkg::item_t              item,
  output logic                        job_push,
  output trd_pkg::job_t               job
);

  logic [1:0]                  depth_mode;
  logic                        rle_enable;
  logic                        palette_enable;
  logic [trd_pkg::FRAME_W-1:0] pixel_total;

  logic [1:0]                  byte_phase, byte_phase_next;
  logic [31:0]                 pixel_assembly, pixel_assembly_next;
  logic                        await_header, await_header_next;
  logic                        packet_is_run, packet_is_run_next;
  logic [7:0]                  packet_left, packet_left_next;
  logic [trd_pkg::FRAME_W-1:0] frame_left, frame_left_next;

  logic                        cfg_write;
  logic                        is_header;
  logic                        complete;
  logic [31:0]                 v;
  logic [7:0]                  ppl, rep, rep_c;
  logic [trd_pkg::FRAME_W-1:0] fpl, fpl_rem, reload;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign reload    = (pixel_total == '0) ? trd_pkg::FRAME_W'(1) : pixel_total;

  always_comb begin
    byte_phase_next     = byte_phase;
    pixel_assembly_next = pixel_assembly;
    await_header_next   = await_header;
    packet_is_run_next  = packet_is_run;
    packet_left_next    = packet_left;
    frame_left_next     = frame_left;
    job_push            = 1'b0;
    is_header           = rle_enable && await_header;
    v                   = pixel_assembly |
                          (32'(item.data_byte) << {byte_phase, 3'b000});
    complete            = (byte_phase == 2'd3) ||
                          ({1'b0, byte_phase + 2'd1} >= ({1'b0, depth_mode} + 3'd1));
    ppl                 = (packet_left == '0) ? 8'd1 : packet_left;
    rep                 = (rle_enable && packet_is_run) ? ppl : 8'd1;
    fpl                 = (frame_left == '0) ? trd_pkg::FRAME_W'(1) : frame_left;
    rep_c               = (trd_pkg::FRAME_W'(rep) > fpl) ? fpl[7:0] : rep;
    fpl_rem             = fpl - trd_pkg::FRAME_W'(rep_c);

    job.op        = trd_pkg::OP_PIXEL;
    job.index     = v[7:0];
    job.blue      = v[7:0];
    job.green     = v[15:8];
    job.red       = v[23:16];
    job.alpha     = trd_pkg::ALPHA_OPAQUE;
    job.rep       = rep_c;
    job.frame_end = (fpl_rem == '0);

    unique case (depth_mode)
      trd_pkg::DEPTH_8: begin
        if (palette_enable) begin
          job.op = trd_pkg::OP_PAL_PIXEL;
        end else begin
          job.green = v[7:0];
          job.red   = v[7:0];
        end
      end
      trd_pkg::DEPTH_16: begin
        job.blue  = {v[4:0], 3'b000};
        job.green = {v[9:5], 3'b000};
        job.red   = {v[14:10], 3'b000};
        job.alpha = v[15] ? trd_pkg::ALPHA_OPAQUE : 8'd0;
      end
      trd_pkg::DEPTH_24: begin
      end
      trd_pkg::DEPTH_32: begin
        job.alpha = v[31:24];
      end
      default: begin
      end
    endcase

    if (item.func == trd_pkg::FUNC_PAL_WRITE) begin
      job.op    = trd_pkg::OP_PAL_WRITE;
      job.index = item.pal_index;
      job.blue  = item.pal_blue;
      job.green = item.pal_green;
      job.red   = item.pal_red;
    end

    if (cfg_write && cfg_index == trd_pkg::CFG_PIXEL_TOTAL) begin
      byte_phase_next     = '0;
      pixel_assembly_next = '0;
      await_header_next   = 1'b1;
      packet_is_run_next  = 1'b0;
      packet_left_next    = '0;
      frame_left_next     = (cfg_data == '0) ? trd_pkg::FRAME_W'(1) : cfg_data;
    end else if (accept) begin
      if (item.func == trd_pkg::FUNC_PAL_WRITE) begin
        job_push = 1'b1;
      end else if (is_header) begin
        packet_is_run_next  = item.data_byte[7];
        packet_left_next    = (item.data_byte & trd_pkg::RUN_MASK) + 8'd1;
        await_header_next   = 1'b0;
        byte_phase_next     = '0;
        pixel_assembly_next = '0;
      end else if (!complete) begin
        byte_phase_next     = byte_phase + 2'd1;
        pixel_assembly_next = v;
      end else begin
        job_push            = 1'b1;
        byte_phase_next     = '0;
        pixel_assembly_next = '0;
        if (rle_enable) begin
          packet_left_next  = packet_is_run ? 8'd0 : ppl - 8'd1;
          if (packet_is_run || ppl == 8'd1) begin
            await_header_next = 1'b1;
          end
        end
        frame_left_next = fpl_rem;
        if (fpl_rem == '0) begin
          frame_left_next    = reload;
          await_header_next  = 1'b1;
          packet_is_run_next = 1'b0;
          packet_left_next   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode     <= trd_pkg::DEPTH_24;
      rle_enable     <= 1'b0;
      palette_enable <= 1'b0;
      pixel_total    <= trd_pkg::FRAME_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        trd_pkg::CFG_DEPTH_MODE:     depth_mode     <= cfg_data[1:0];
        trd_pkg::CFG_RLE_ENABLE:     rle_enable     <= cfg_data[0];
        trd_pkg::CFG_PALETTE_ENABLE: palette_enable <= cfg_data[0];
        trd_pkg::CFG_PIXEL_TOTAL:    pixel_total    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= '0;
      pixel_assembly <= '0;
      await_header   <= 1'b1;
      packet_is_run  <= 1'b0;
      packet_left    <= '0;
      frame_left     <= trd_pkg::FRAME_W'(1);
    end else begin
      byte_phase     <= byte_phase_next;
      pixel_assembly <= pixel_assembly_next;
      await_header   <= await_header_next;
      packet_is_run  <= packet_is_run_next;
      packet_left    <= packet_left_next;
      frame_left     <= frame_left_next;
    end
  end

  a_frame_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    frame_left != '0)
    else $error("frame counter reached zero without reload");

  a_header_no_job: assert property (@(posedge clk) disable iff (rst)
    accept && item.func != trd_pkg::FUNC_PAL_WRITE && is_header |-> !job_push)
    else $error("packet header produced a job");

endmodule

/* rtl/trd_job_fifo.sv */
// Two-entry queue of jobs between front and back end.
// Uses trd_pkg job_t.
`timescale 1ns / 1ps

module trd_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  trd_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output trd_pkg::job_t head
);

  trd_pkg::job_t store [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* rtl/trd_back.sv */
// Back end: palette memory with registered read, pixel forming and a
// two-entry result queue. Uses trd_pkg job_t and result_t.
`timescale 1ns / 1ps

module trd_back #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             jq_empty,
  input  trd_pkg::job_t    jq_head,
  output logic             jq_pop,
  output logic             empty,
  input  logic             pop,
  output trd_pkg::result_t result
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0]      palette [PALETTE_ENTRIES];
  logic [23:0]      rd_data;
  logic             in_range;
  logic [AW-1:0]    addr;

  logic             s1_valid;
  trd_pkg::job_t    s1_job;
  logic             s1_in_range;
  logic             load;
  logic             out_push;
  trd_pkg::result_t formed;

  trd_pkg::result_t oq [2];
  logic             oq_wr;
  logic             oq_rd;
  logic [1:0]       oq_count;
  logic             oq_full;
  logic             oq_pop;

  assign in_range = ({1'b0, jq_head.index} < 9'(PALETTE_ENTRIES));
  assign addr     = jq_head.index[AW-1:0];
  assign oq_full  = (oq_count == 2'd2);
  assign out_push = s1_valid && !oq_full;
  assign load     = !jq_empty && (!s1_valid || out_push);
  assign jq_pop   = load;
  assign empty    = (oq_count == 2'd0);
  assign oq_pop   = pop && !empty;
  assign result   = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (load && in_range) begin
      if (jq_head.op == trd_pkg::OP_PAL_WRITE) begin
        palette[addr] <= {jq_head.red, jq_head.green, jq_head.blue};
      end else begin
        rd_data <= palette[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_job      <= jq_head;
      s1_in_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= (jq_head.op != trd_pkg::OP_PAL_WRITE);
    end else if (out_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    formed.out_blue     = s1_job.blue;
    formed.out_green    = s1_job.green;
    formed.out_red      = s1_job.red;
    formed.out_alpha    = s1_job.alpha;
    formed.repeat_count = s1_job.rep;
    formed.frame_end    = s1_job.frame_end;
    if (s1_job.op == trd_pkg::OP_PAL_PIXEL) begin
      formed.out_blue  = s1_in_range ? rd_data[7:0]   : 8'd0;
      formed.out_green = s1_in_range ? rd_data[15:8]  : 8'd0;
      formed.out_red   = s1_in_range ? rd_data[23:16] : 8'd0;
      formed.out_alpha = trd_pkg::ALPHA_OPAQUE;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      oq[oq_wr] <= formed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= '0;
    end else begin
      if (out_push) oq_wr <= ~oq_wr;
      if (oq_pop)   oq_rd <= ~oq_rd;
      oq_count <= oq_count + {1'b0, out_push} - {1'b0, oq_pop};
    end
  end

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    load && jq_head.op == trd_pkg::OP_PAL_WRITE |=> !s1_valid)
    else $error("palette write request reached the result stage");

  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count <= 2'd2)
    else $error("result queue overflow");

  a_rep_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.repeat_count != 8'd0 && result.repeat_count <= 8'd128))
    else $error("repeat count out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && oq_full |=> s1_valid && $stable(s1_job))
    else $error("stalled pixel lost");

endmodule

/* rtl/tga_rle_pixel_decoder.sv */
// TGA RLE pixel decoder: turns the pixel byte stream of a TGA image (after
// header, ID field and colour map) plus interleaved palette writes into BGRA
// pixels with a repeat count, flagging the pixel that completes the frame.
// Sustains one input request per clock while the job queue is not full; a pixel
// result passes through the job queue, then the palette read register, then the
// result queue before it is shown.
// The palette is a PALETTE_ENTRIES x 24 bit memory with one port and no reset:
// an entry must be written before a pixel reads it. Configure while idle.
// Uses trd_pkg, trd_front, trd_job_fifo and trd_back.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  trd_pkg::item_t              item,
  output logic                        empty,
  input  logic                        pop,
  output trd_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [trd_pkg::FRAME_W-1:0] cfg_data
);

  logic          job_push;
  trd_pkg::job_t job;
  logic          jq_empty;
  logic          jq_pop;
  trd_pkg::job_t jq_head;

  trd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (push && !full),
    .item      (item),
    .job_push  (job_push),
    .job       (job)
  );

  trd_job_fifo u_job_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job),
    .full  (full),
    .pop   (jq_pop),
    .empty (jq_empty),
    .head  (jq_head)
  );

  trd_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .jq_empty (jq_empty),
    .jq_head  (jq_head),
    .jq_pop   (jq_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

/* dv/trd_pixel_checker.sv */
// Checker for the TGA RLE pixel decoder: watches the request, result and register
// channels, predicts each decoded pixel and compares it field by field.
// Depends on trd_pkg; hands its mismatch count and queue depth to the testbench top.
`timescale 1ns / 1ps

module trd_pixel_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  trd_pkg::item_t              item,
  input  logic                        empty,
  input  logic                        pop,
  input  trd_pkg::result_t            result,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [trd_pkg::FRAME_W-1:0] cfg_data,
  output int                          mismatches,
  output int                          pending
);

  logic [1:0]                  depth;
  logic                        rle_on;
  logic                        pal_on;
  logic [trd_pkg::FRAME_W-1:0] total;

  logic [1:0]                  phase_cnt;
  logic [31:0]                 assembled;
  logic                        need_header;
  logic                        in_run;
  logic [7:0]                  pkt_left;
  logic [trd_pkg::FRAME_W-1:0] frame_left;
  logic [23:0]                 bgr_table [256];

  trd_pkg::result_t            expected_px [$];
  trd_pkg::result_t            want;

  task automatic restart_frame();
    frame_left  = (total == '0) ? trd_pkg::FRAME_W'(1) : total;
    need_header = 1'b1;
    in_run      = 1'b0;
    pkt_left    = 8'd0;
    phase_cnt   = 2'd0;
    assembled   = 32'd0;
  endtask

  task automatic apply_register(input logic [1:0] idx,
                                input logic [trd_pkg::FRAME_W-1:0] val);
    case (idx)
      trd_pkg::CFG_DEPTH_MODE:     depth = val[1:0];
      trd_pkg::CFG_RLE_ENABLE:     rle_on = val[0];
      trd_pkg::CFG_PALETTE_ENABLE: pal_on = val[0];
      trd_pkg::CFG_PIXEL_TOTAL: begin
        total = val;
        restart_frame();
      end
      default: ;
    endcase
  endtask

  task automatic decode_request(input trd_pkg::item_t it);
    logic [7:0]  b, g, r, a;
    int unsigned rep_n;
    logic        done;
    if (it.func == trd_pkg::FUNC_PAL_WRITE) begin
      bgr_table[it.pal_index] = {it.pal_red, it.pal_green, it.pal_blue};
    end else if (rle_on && need_header) begin
      in_run      = it.data_byte[7];
      pkt_left    = {1'b0, it.data_byte[6:0]} + 8'd1;
      need_header = 1'b0;
      phase_cnt   = 2'd0;
      assembled   = 32'd0;
    end else begin
      assembled = assembled | (32'(it.data_byte) << (8 * phase_cnt));
      phase_cnt = phase_cnt + 2'd1;
      if (phase_cnt == 2'd0 || {1'b0, phase_cnt} >= {1'b0, depth} + 3'd1) begin
        case (depth)
          trd_pkg::DEPTH_8: begin
            if (pal_on) {r, g, b} = bgr_table[assembled[7:0]];
            else {r, g, b} = {3{assembled[7:0]}};
            a = trd_pkg::ALPHA_OPAQUE;
          end
          trd_pkg::DEPTH_16: begin
            b = {assembled[4:0], 3'b000};
            g = {assembled[9:5], 3'b000};
            r = {assembled[14:10], 3'b000};
            a = assembled[15] ? trd_pkg::ALPHA_OPAQUE : 8'd0;
          end
          trd_pkg::DEPTH_24: begin
            {r, g, b} = assembled[23:0];
            a = trd_pkg::ALPHA_OPAQUE;
          end
          default: {a, r, g, b} = assembled;
        endcase
        phase_cnt = 2'd0;
        assembled = 32'd0;
        rep_n = 1;
        if (rle_on) begin
          if (pkt_left == 8'd0) pkt_left = 8'd1;
          if (in_run) begin
            rep_n    = pkt_left;
            pkt_left = 8'd0;
          end else begin
            pkt_left = pkt_left - 8'd1;
          end
          if (pkt_left == 8'd0) need_header = 1'b1;
        end
        if (frame_left == '0) frame_left = trd_pkg::FRAME_W'(1);
        if (rep_n > frame_left) rep_n = frame_left;
        frame_left = frame_left - rep_n[trd_pkg::FRAME_W-1:0];
        done = (frame_left == '0);
        if (done) restart_frame();
        expected_px.push_back('{b, g, r, a, rep_n[7:0], done});
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_px.delete();
      mismatches = 0;
      depth  = trd_pkg::DEPTH_24;
      rle_on = 1'b0;
      pal_on = 1'b0;
      total  = trd_pkg::FRAME_W'(1);
      restart_frame();
    end else begin
      if (pop && !empty) begin
        if (expected_px.size() == 0) begin
          $error("result request with no pixel expected");
          mismatches++;
        end else begin
          want = expected_px.pop_front();
          check_field("out_blue", want.out_blue, result.out_blue);
          check_field("out_green", want.out_green, result.out_green);
          check_field("out_red", want.out_red, result.out_red);
          check_field("out_alpha", want.out_alpha, result.out_alpha);
          check_field("repeat_count", want.repeat_count, result.repeat_count);
          check_field("frame_end", 8'(want.frame_end), 8'(result.frame_end));
        end
      end
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (push && !full) decode_request(item);
    end
    pending = expected_px.size();
  end

endmodule

/* dv/tb_tga_rle_pixel_decoder.sv */
// Testbench top for the TGA RLE pixel decoder: clock, reset, request and register
// stimulus with random idling on both sides, and the final verdict.
// Depends on trd_pkg, tga_rle_pixel_decoder and trd_pixel_checker.
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;

  localparam logic                        FUNC_PIXEL = 1'b1;
  localparam logic [trd_pkg::FRAME_W-1:0] PIXEL_MAX  = 30'd1073676289;
  localparam int                          PHASE_REQS = 390;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        push      = 1'b0;
  logic                        full;
  trd_pkg::item_t              item      = '0;
  logic                        empty;
  logic                        pop       = 1'b0;
  trd_pkg::result_t            result;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index = trd_pkg::CFG_DEPTH_MODE;
  logic [trd_pkg::FRAME_W-1:0] cfg_data  = '0;

  int mismatches;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;
  int sent      = 0;
  int reg_writes = 0;

  tga_rle_pixel_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  trd_pixel_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(input trd_pkg::item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item('{FUNC_PIXEL, b, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte()});
  endtask

  task automatic send_pal(input logic [7:0] idx, input logic [7:0] b,
                          input logic [7:0] g, input logic [7:0] r);
    send_item('{trd_pkg::FUNC_PAL_WRITE, rnd_byte(), idx, b, g, r});
  endtask

  // Only while idle: push dropped and every result drained before the register write.
  task automatic write_reg(input logic [1:0] idx,
                           input logic [trd_pkg::FRAME_W-1:0] val);
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // Mostly well-formed pixels or packets with random content, some noise.
  task automatic send_stream(input int n, input logic [1:0] dm, input logic rle);
    int          stop;
    int          bpp;
    int          npx;
    int unsigned roll;
    logic [7:0]  hdr;
    stop = sent + n;
    bpp  = int'(dm) + 1;
    while (sent < stop) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        send_pal(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
      end else if (roll < 10) begin
        send_byte(rnd_byte());
      end else if (rle) begin
        hdr = rnd_byte();
        if ($urandom_range(3) != 0) hdr[6:0] = 7'($urandom_range(7));
        send_byte(hdr);
        npx = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
        for (int k = 0; k < npx * bpp && sent < stop; k++) send_byte(rnd_byte());
      end else begin
        for (int k = 0; k < bpp; k++) send_byte(rnd_byte());
      end
    end
  endtask

  initial begin
    int                          phase_start;
    logic [1:0]                  dm;
    logic                        rle;
    logic [trd_pkg::FRAME_W-1:0] tot;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 256; i++) begin
      if (i == 0) send_pal(8'd0, 8'h00, 8'h00, 8'h00);
      else if (i == 255) send_pal(8'hff, 8'hff, 8'hff, 8'hff);
      else send_pal(8'(i), rnd_byte(), rnd_byte(), rnd_byte());
    end

    send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hff); send_byte(8'hff); send_byte(8'hff);
    write_reg(trd_pkg::CFG_DEPTH_MODE, trd_pkg::FRAME_W'(trd_pkg::DEPTH_16));
    write_reg(trd_pkg::CFG_PIXEL_TOTAL, 30'd2);
    send_byte(8'h00); send_byte(8'h80);
    send_byte(8'hff); send_byte(8'h7f);
    write_reg(trd_pkg::CFG_DEPTH_MODE, trd_pkg::FRAME_W'(trd_pkg::DEPTH_32));
    send_byte(8'h12); send_byte(8'h34);
    // depth drops mid-pixel: the next byte completes it
    write_reg(trd_pkg::CFG_DEPTH_MODE, trd_pkg::FRAME_W'(trd_pkg::DEPTH_16));
    send_byte(8'h56);
    write_reg(trd_pkg::CFG_DEPTH_MODE, trd_pkg::FRAME_W'(trd_pkg::DEPTH_8));
    write_reg(trd_pkg::CFG_PALETTE_ENABLE, 30'd1);
    send_byte(8'h00); send_byte(8'hff);
    write_reg(trd_pkg::CFG_PALETTE_ENABLE, 30'd0);
    send_byte(8'h7f);
    write_reg(trd_pkg::CFG_RLE_ENABLE, 30'd1);
    write_reg(trd_pkg::CFG_PIXEL_TOTAL, 30'd5);
    send_byte(8'hff); send_byte(8'haa);
    write_reg(trd_pkg::CFG_PIXEL_TOTAL, 30'd2);
    send_byte(8'h7f); send_byte(8'h01); send_byte(8'h02);
    send_byte(8'h83); send_byte(8'h44);
    send_byte(8'h80); send_byte(8'h55);
    write_reg(trd_pkg::CFG_RLE_ENABLE, 30'd0);
    write_reg(trd_pkg::CFG_PIXEL_TOTAL, 30'd0);
    send_byte(8'h09);
    write_reg(trd_pkg::CFG_PIXEL_TOTAL, PIXEL_MAX);
    send_byte(8'hc3);

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 32 : (p == 1) ? 65 : 0;
      recv_idle = (p == 0) ? 65 : (p == 1) ? 32 : 0;
      phase_start = sent;
      while (sent - phase_start < PHASE_REQS) begin
        dm  = 2'($urandom_range(3));
        rle = 1'($urandom_range(1));
        case ($urandom_range(9))
          0:       tot = PIXEL_MAX;
          1:       tot = trd_pkg::FRAME_W'(1);
          default: tot = trd_pkg::FRAME_W'($urandom_range(40, 2));
        endcase
        write_reg(trd_pkg::CFG_DEPTH_MODE, trd_pkg::FRAME_W'(dm));
        write_reg(trd_pkg::CFG_RLE_ENABLE, trd_pkg::FRAME_W'(rle));
        write_reg(trd_pkg::CFG_PALETTE_ENABLE, 30'($urandom_range(1)));
        write_reg(trd_pkg::CFG_PIXEL_TOTAL, tot);
        send_stream($urandom_range(60, 20), dm, rle);
      end
    end

    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Run covered %0d requests (palette writes and bytes), %0d register writes,",
             sent, reg_writes);
    $display("all four depths, gray and palette, raw and run packets, clipped runs and frame ends.");
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ERROR: run did not finish in time, %0d pixels still outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule
